// ----- src/first_fit_heap_allocator_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFHA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ffha_pkg.sv -----
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes of the first-fit heap allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;

    localparam logic [23:0] ALIGN_MASK24 = 24'hFFFFF0;
    localparam logic [24:0] ALIGN_MASK25 = 25'h1FFFFF0;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    typedef enum logic [2:0] {
        ACT_ALLOC_FRONT,
        ACT_ALLOC_BACK,
        ACT_FREE,
        ACT_RESIZE,
        ACT_SIZES,
        ACT_CLEAR,
        ACT_INIT
    } act_t;

    typedef enum logic [1:0] {
        STS_DONE,
        STS_NO_SPACE,
        STS_TABLE_FULL,
        STS_IGNORED
    } sts_t;

    typedef enum logic [2:0] {
        OP_FRONT,
        OP_BACK,
        OP_FREE,
        OP_RESIZE,
        OP_SIZES
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_TAIL,
        S_BWALK,
        S_FIT,
        S_SCAN,
        S_LINK_A,
        S_LINK_B,
        S_FREE_Q,
        S_FREE_P,
        S_RSZ_Q,
        S_RSZ_E,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [23:0] offset;
        logic [23:0] payload;
        logic        is_free;
    } blk_t;

endpackage

`default_nettype wire

// ----- src/first_fit_heap_allocator.sv -----
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// Address-ordered block table with first-fit allocation from either end,
// freeing with coalescing, resize and a sizes query.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | action, block_address, request_bytes
//  out     | out_valid / out_stall | status, result_address, largest_free,
//          |                       | total_free, total_alloc, heap_ready
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item at a time. A list walk visits the blocks in turn through the
//  table read port; a split adds a free-entry scan over up to MAX_BLOCKS
//  entries and the link states S_LINK_A and S_LINK_B. A moving resize walks
//  the list up to three times.
//  Reset clears the valid bits of the table at once; no clearing pass.
//  A result waiting on out_stall does not block the next item's acceptance.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic [31:0] block_address,
    input  wire logic [23:0] request_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      result_address,
    output logic [23:0]      largest_free,
    output logic [23:0]      total_free,
    output logic [23:0]      total_alloc,
    output logic             heap_ready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

`include "first_fit_heap_allocator_assert.svh"

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam logic [LW-1:0] NIL   = LW'(MAX_BLOCKS);
    localparam logic [23:0]   HB    = 24'(HEADER_BYTES);
    localparam logic [31:0]   HB32  = 32'(HEADER_BYTES);
    localparam logic [25:0]   HB26  = 26'(HEADER_BYTES);
    localparam logic [IW-1:0] LAST  = IW'(MAX_BLOCKS - 1);

    function automatic sts_t end_sts(input op_t o);
        sts_t s;
        case (o)
            OP_FRONT: s = STS_NO_SPACE;
            OP_SIZES: s = STS_DONE;
            default:  s = STS_IGNORED;
        endcase
        return s;
    endfunction

    fsm_t state_reg, state_next;
    op_t  op_reg, op_next;
    act_t act_reg, act_next;
    logic move_reg, move_next;
    logic [31:0] addr_reg, addr_next;
    logic [24:0] size_reg, size_next;
    logic        req_zero_reg, req_zero_next;
    logic [LW-1:0] e_reg, e_next;
    logic [IW-1:0] n_reg, n_next;
    logic [IW-1:0] scan_reg, scan_next;
    blk_t          cur_reg, cur_next;
    logic [LW-1:0] cur_nxt_reg, cur_nxt_next;
    logic [LW-1:0] cur_prv_reg, cur_prv_next;
    logic [LW-1:0] first_reg, first_next;
    logic [MAX_BLOCKS-1:0] in_use_reg, in_use_next;
    logic init_done_reg, init_done_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] hbase_reg, hbase_next;
    logic [23:0] hsize_reg, hsize_next;
    sts_t        sts_reg, sts_next;
    logic [31:0] res_reg, res_next;
    logic [23:0] big_reg, big_next;
    logic [23:0] tfree_reg, tfree_next;
    logic [23:0] talloc_reg, talloc_next;
    logic        out_valid_reg, out_valid_next;
    sts_t        out_sts_reg, out_sts_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic [23:0] out_big_reg, out_big_next;
    logic [23:0] out_tfree_reg, out_tfree_next;
    logic [23:0] out_talloc_reg, out_talloc_next;
    logic        out_ready_reg, out_ready_next;

    // table ports
    logic [IW-1:0] rd_idx;
    blk_t          rd_data;
    logic [LW-1:0] rd_nxt, rd_prv;
    logic          dat_we, nxt_we, prv_we;
    logic [IW-1:0] dat_idx, nxt_idx, prv_idx;
    blk_t          dat_wd;
    logic [LW-1:0] nxt_wd, prv_wd;

    ffha_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
        .clk     (clk),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .rd_nxt  (rd_nxt),
        .rd_prv  (rd_prv),
        .dat_we  (dat_we),
        .dat_idx (dat_idx),
        .dat_wd  (dat_wd),
        .nxt_we  (nxt_we),
        .nxt_idx (nxt_idx),
        .nxt_wd  (nxt_wd),
        .prv_we  (prv_we),
        .prv_idx (prv_idx),
        .prv_wd  (prv_wd)
    );

    // conditions
    logic accept, out_free, first_nil;
    logic rd_nxt_nil, rd_prv_nil, cur_nxt_nil, cur_prv_nil;
    logic fits, rd_addr_hit, walk_hit;
    logic [25:0] blk;
    logic split;
    logic [23:0] cur_end, p_end, n_off, res_off;
    logic merge_q, merge_p, grow_need, grow_ok;
    logic [24:0] diff;
    logic [31:0] rd_pay_addr, cur_pay_addr;
    logic scan_free, scan_last;
    logic [3:0]  hdiff;
    logic [23:0] asz;
    logic init_bad;
    op_t  start_op;
    logic start_walks;

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_free    = !out_valid_reg || !out_stall;
    assign first_nil   = (first_reg == NIL);
    assign rd_nxt_nil  = (rd_nxt == NIL);
    assign rd_prv_nil  = (rd_prv == NIL);
    assign cur_nxt_nil = (cur_nxt_reg == NIL);
    assign cur_prv_nil = (cur_prv_reg == NIL);
    assign fits        = rd_data.is_free && ({1'b0, rd_data.payload} >= size_reg);
    assign rd_pay_addr = base_reg + {8'b0, rd_data.offset} + HB32;
    assign rd_addr_hit = (rd_pay_addr == addr_reg);
    assign walk_hit    = (op_reg == OP_FRONT) ? fits :
                         ((op_reg == OP_FREE) || (op_reg == OP_RESIZE)) ? rd_addr_hit : 1'b0;
    assign blk         = {1'b0, size_reg} + HB26;
    assign split       = blk < {2'b0, cur_reg.payload};
    assign cur_end     = cur_reg.offset + HB + cur_reg.payload;
    assign p_end       = rd_data.offset + HB + rd_data.payload;
    assign merge_q     = !cur_nxt_nil && rd_data.is_free && (rd_data.offset == cur_end);
    assign merge_p     = !cur_prv_nil && rd_data.is_free && (cur_reg.offset == p_end);
    assign grow_need   = size_reg > {1'b0, cur_reg.payload};
    assign diff        = size_reg - {1'b0, cur_reg.payload};
    assign grow_ok     = merge_q && ({1'b0, rd_data.payload} >= diff);
    assign n_off       = cur_reg.offset + cur_reg.payload - size_reg[23:0];
    assign res_off     = ((state_reg == S_LINK_A) && (op_reg == OP_BACK)) ? n_off
                                                                          : cur_reg.offset;
    assign cur_pay_addr = base_reg + {8'b0, res_off} + HB32;
    assign scan_free   = !in_use_reg[scan_reg];
    assign scan_last   = (scan_reg == LAST);
    assign hdiff       = 4'd0 - hbase_reg[3:0];
    assign asz         = (hsize_reg - {20'b0, hdiff}) & ALIGN_MASK24;
    assign init_bad    = (hbase_reg == 32'd0) || (hsize_reg < {20'b0, hdiff}) || (asz <= HB);

    always_comb
    begin
        case (act_reg)
            ACT_ALLOC_BACK: start_op = OP_BACK;
            ACT_FREE:       start_op = OP_FREE;
            ACT_RESIZE:     start_op = (addr_reg == 32'd0) ? OP_FRONT :
                                       req_zero_reg ? OP_FREE : OP_RESIZE;
            ACT_SIZES:      start_op = OP_SIZES;
            default:        start_op = OP_FRONT;
        endcase
        start_walks = (act_reg == ACT_ALLOC_FRONT) || (act_reg == ACT_RESIZE) ||
                      (act_reg == ACT_SIZES) ||
                      ((act_reg == ACT_FREE) && (addr_reg != 32'd0));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (start_walks)
                begin
                    state_next = first_nil ? S_DONE : S_WALK;
                end
                else if (act_reg == ACT_ALLOC_BACK)
                begin
                    state_next = first_nil ? S_DONE : S_TAIL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (walk_hit)
                begin
                    if (op_reg == OP_FRONT)
                    begin
                        state_next = S_FIT;
                    end
                    else if (rd_data.is_free)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = (op_reg == OP_FREE) ? S_FREE_Q : S_RSZ_Q;
                    end
                end
                else if (rd_nxt_nil)
                begin
                    state_next = S_DONE;
                end
            end
            S_TAIL:
            begin
                if (rd_nxt_nil)
                begin
                    state_next = S_BWALK;
                end
            end
            S_BWALK:
            begin
                if (fits)
                begin
                    state_next = S_FIT;
                end
                else if (rd_prv_nil)
                begin
                    state_next = S_DONE;
                end
            end
            S_FIT:
            begin
                if (split)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = move_reg ? S_WALK : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_free)
                begin
                    state_next = S_LINK_A;
                end
                else if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK_A: state_next = S_LINK_B;
            S_LINK_B: state_next = move_reg ? S_WALK : S_DONE;
            S_FREE_Q: state_next = S_FREE_P;
            S_FREE_P: state_next = S_DONE;
            S_RSZ_Q:
            begin
                if (!grow_need)
                begin
                    state_next = S_DONE;
                end
                else if (grow_ok)
                begin
                    state_next = S_RSZ_E;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_RSZ_E: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and table control
    always_comb
    begin
        op_next        = op_reg;
        act_next       = act_reg;
        move_next      = move_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        req_zero_next  = req_zero_reg;
        e_next         = e_reg;
        n_next         = n_reg;
        scan_next      = scan_reg;
        cur_next       = cur_reg;
        cur_nxt_next   = cur_nxt_reg;
        cur_prv_next   = cur_prv_reg;
        first_next     = first_reg;
        in_use_next    = in_use_reg;
        init_done_next = init_done_reg;
        base_next      = base_reg;
        hbase_next     = hbase_reg;
        hsize_next     = hsize_reg;
        sts_next       = sts_reg;
        res_next       = res_reg;
        big_next       = big_reg;
        tfree_next     = tfree_reg;
        talloc_next    = talloc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_sts_next    = out_sts_reg;
        out_addr_next   = out_addr_reg;
        out_big_next    = out_big_reg;
        out_tfree_next  = out_tfree_reg;
        out_talloc_next = out_talloc_reg;
        out_ready_next  = out_ready_reg;

        rd_idx  = e_reg[IW-1:0];
        dat_we  = 1'b0;
        dat_idx = e_reg[IW-1:0];
        dat_wd  = cur_reg;
        nxt_we  = 1'b0;
        nxt_idx = e_reg[IW-1:0];
        nxt_wd  = NIL;
        prv_we  = 1'b0;
        prv_idx = e_reg[IW-1:0];
        prv_wd  = NIL;

        if (cfg_valid)
        begin
            if (cfg_index == CFG_HEAP_BASE)
            begin
                hbase_next = cfg_data;
            end
            else
            begin
                hsize_next = cfg_data[23:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next      = act_t'(action);
                    addr_next     = block_address;
                    size_next     = ({1'b0, request_bytes} + 25'd15) & ALIGN_MASK25;
                    req_zero_next = (request_bytes == 24'd0);
                    sts_next      = STS_DONE;
                    res_next      = 32'd0;
                    big_next      = 24'd0;
                    tfree_next    = 24'd0;
                    talloc_next   = 24'd0;
                    move_next     = 1'b0;
                end
            end
            S_START:
            begin
                op_next = start_op;
                case (act_reg)
                    ACT_CLEAR:
                    begin
                        in_use_next    = '0;
                        first_next     = NIL;
                        init_done_next = 1'b0;
                    end
                    ACT_INIT:
                    begin
                        in_use_next    = '0;
                        first_next     = NIL;
                        init_done_next = 1'b1;
                        base_next      = hbase_reg + {28'b0, hdiff};
                        if (init_bad)
                        begin
                            sts_next = STS_NO_SPACE;
                        end
                        else
                        begin
                            in_use_next[0] = 1'b1;
                            first_next     = '0;
                            dat_we         = 1'b1;
                            dat_idx        = '0;
                            dat_wd         = '{offset: 24'd0, payload: asz - HB, is_free: 1'b1};
                            nxt_we         = 1'b1;
                            nxt_idx        = '0;
                            prv_we         = 1'b1;
                            prv_idx        = '0;
                        end
                    end
                    ACT_ALLOC_BACK:
                    begin
                        if (first_nil)
                        begin
                            sts_next = STS_NO_SPACE;
                        end
                        else
                        begin
                            rd_idx = first_reg[IW-1:0];
                            e_next = first_reg;
                        end
                    end
                    ACT_ALLOC_FRONT, ACT_FREE, ACT_RESIZE, ACT_SIZES:
                    begin
                        if (!start_walks)
                        begin
                            sts_next = STS_IGNORED;
                        end
                        else if (first_nil)
                        begin
                            sts_next = end_sts(start_op);
                        end
                        else
                        begin
                            rd_idx = first_reg[IW-1:0];
                            e_next = first_reg;
                        end
                    end
                    default: sts_next = STS_IGNORED;
                endcase
            end
            S_WALK:
            begin
                // prefetch the successor; on a hit it is the right neighbour
                rd_idx = rd_nxt[IW-1:0];
                if (op_reg == OP_SIZES)
                begin
                    if (rd_data.is_free)
                    begin
                        tfree_next = tfree_reg + rd_data.payload;
                        if (big_reg < rd_data.payload)
                        begin
                            big_next = rd_data.payload;
                        end
                    end
                    else
                    begin
                        talloc_next = talloc_reg + rd_data.payload;
                    end
                end
                if (walk_hit)
                begin
                    cur_next     = rd_data;
                    cur_nxt_next = rd_nxt;
                    cur_prv_next = rd_prv;
                    if ((op_reg != OP_FRONT) && rd_data.is_free)
                    begin
                        sts_next = STS_IGNORED;
                    end
                end
                else if (rd_nxt_nil)
                begin
                    sts_next = end_sts(op_reg);
                end
                else
                begin
                    e_next = rd_nxt;
                end
            end
            S_TAIL:
            begin
                if (rd_nxt_nil)
                begin
                    rd_idx = e_reg[IW-1:0];
                end
                else
                begin
                    rd_idx = rd_nxt[IW-1:0];
                    e_next = rd_nxt;
                end
            end
            S_BWALK:
            begin
                if (fits)
                begin
                    cur_next     = rd_data;
                    cur_nxt_next = rd_nxt;
                    cur_prv_next = rd_prv;
                end
                else if (rd_prv_nil)
                begin
                    sts_next = STS_NO_SPACE;
                end
                else
                begin
                    rd_idx = rd_prv[IW-1:0];
                    e_next = rd_prv;
                end
            end
            S_FIT:
            begin
                scan_next = '0;
                if (!split)
                begin
                    dat_we         = 1'b1;
                    dat_wd.is_free = 1'b0;
                    res_next       = cur_pay_addr;
                    if (move_reg)
                    begin
                        // moved resize: now free the old block
                        rd_idx    = first_reg[IW-1:0];
                        e_next    = first_reg;
                        op_next   = OP_FREE;
                        move_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_free)
                begin
                    n_next = scan_reg;
                end
                else if (scan_last)
                begin
                    sts_next = STS_TABLE_FULL;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_LINK_A:
            begin
                in_use_next[n_reg] = 1'b1;
                dat_we  = 1'b1;
                dat_idx = n_reg;
                if (op_reg == OP_BACK)
                begin
                    dat_wd = '{offset: n_off, payload: size_reg[23:0], is_free: 1'b0};
                end
                else
                begin
                    dat_wd = '{offset: cur_reg.offset + blk[23:0],
                               payload: cur_reg.payload - blk[23:0], is_free: 1'b1};
                end
                nxt_we  = 1'b1;
                nxt_idx = n_reg;
                nxt_wd  = cur_nxt_reg;
                prv_we  = 1'b1;
                prv_idx = n_reg;
                prv_wd  = e_reg;
                res_next = cur_pay_addr;
            end
            S_LINK_B:
            begin
                prv_we  = !cur_nxt_nil;
                prv_idx = cur_nxt_reg[IW-1:0];
                prv_wd  = LW'(n_reg);
                nxt_we  = 1'b1;
                nxt_wd  = LW'(n_reg);
                dat_we  = 1'b1;
                if (op_reg == OP_BACK)
                begin
                    dat_wd = '{offset: cur_reg.offset,
                               payload: cur_reg.payload - blk[23:0], is_free: 1'b1};
                end
                else
                begin
                    dat_wd = '{offset: cur_reg.offset, payload: size_reg[23:0], is_free: 1'b0};
                end
                if (move_reg)
                begin
                    rd_idx    = first_reg[IW-1:0];
                    e_next    = first_reg;
                    op_next   = OP_FREE;
                    move_next = 1'b0;
                end
            end
            S_FREE_Q:
            begin
                rd_idx  = cur_prv_reg[IW-1:0];
                dat_we  = 1'b1;
                dat_wd.is_free = 1'b1;
                if (merge_q)
                begin
                    dat_wd.payload   = cur_reg.payload + rd_data.payload + HB;
                    cur_next.payload = cur_reg.payload + rd_data.payload + HB;
                    cur_nxt_next     = rd_nxt;
                    nxt_we  = 1'b1;
                    nxt_wd  = rd_nxt;
                    prv_we  = !rd_nxt_nil;
                    prv_idx = rd_nxt[IW-1:0];
                    prv_wd  = e_reg;
                    in_use_next[cur_nxt_reg[IW-1:0]] = 1'b0;
                end
            end
            S_FREE_P:
            begin
                if (merge_p)
                begin
                    dat_we  = 1'b1;
                    dat_idx = cur_prv_reg[IW-1:0];
                    dat_wd  = '{offset: rd_data.offset,
                                payload: rd_data.payload + cur_reg.payload + HB,
                                is_free: 1'b1};
                    nxt_we  = 1'b1;
                    nxt_idx = cur_prv_reg[IW-1:0];
                    nxt_wd  = cur_nxt_reg;
                    prv_we  = !cur_nxt_nil;
                    prv_idx = cur_nxt_reg[IW-1:0];
                    prv_wd  = cur_prv_reg;
                    in_use_next[e_reg[IW-1:0]] = 1'b0;
                end
            end
            S_RSZ_Q:
            begin
                if (!grow_need)
                begin
                    res_next = addr_reg;
                end
                else if (grow_ok)
                begin
                    // grow in place into the free successor
                    dat_we  = 1'b1;
                    dat_idx = cur_nxt_reg[IW-1:0];
                    dat_wd  = '{offset: rd_data.offset + diff[23:0],
                                payload: rd_data.payload - diff[23:0], is_free: 1'b1};
                end
                else
                begin
                    rd_idx    = first_reg[IW-1:0];
                    e_next    = first_reg;
                    op_next   = OP_FRONT;
                    move_next = 1'b1;
                end
            end
            S_RSZ_E:
            begin
                dat_we   = 1'b1;
                dat_wd   = '{offset: cur_reg.offset, payload: size_reg[23:0], is_free: 1'b0};
                res_next = addr_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sts_next    = sts_reg;
                    out_addr_next   = (sts_reg == STS_DONE) ? res_reg : 32'd0;
                    out_big_next    = big_reg;
                    out_tfree_next  = tfree_reg;
                    out_talloc_next = talloc_reg;
                    out_ready_next  = init_done_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            move_reg      <= 1'b0;
            first_reg     <= NIL;
            in_use_reg    <= '0;
            init_done_reg <= 1'b0;
            base_reg      <= 32'd0;
            hbase_reg     <= 32'd0;
            hsize_reg     <= 24'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            move_reg      <= move_next;
            first_reg     <= first_next;
            in_use_reg    <= in_use_next;
            init_done_reg <= init_done_next;
            base_reg      <= base_next;
            hbase_reg     <= hbase_next;
            hsize_reg     <= hsize_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        act_reg        <= act_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        req_zero_reg   <= req_zero_next;
        e_reg          <= e_next;
        n_reg          <= n_next;
        scan_reg       <= scan_next;
        cur_reg        <= cur_next;
        cur_nxt_reg    <= cur_nxt_next;
        cur_prv_reg    <= cur_prv_next;
        sts_reg        <= sts_next;
        res_reg        <= res_next;
        big_reg        <= big_next;
        tfree_reg      <= tfree_next;
        talloc_reg     <= talloc_next;
        out_sts_reg    <= out_sts_next;
        out_addr_reg   <= out_addr_next;
        out_big_reg    <= out_big_next;
        out_tfree_reg  <= out_tfree_next;
        out_talloc_reg <= out_talloc_next;
        out_ready_reg  <= out_ready_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_sts_reg;
    assign result_address = out_addr_reg;
    assign largest_free   = out_big_reg;
    assign total_free     = out_tfree_reg;
    assign total_alloc    = out_talloc_reg;
    assign heap_ready     = out_ready_reg;

    `FFHA_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_reg == S_START,
        "accepted item did not start")
    `FFHA_ASSERT_IMP(a_out_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE,
        "result raised outside completion")
    `FFHA_ASSERT_IMP(a_fail_no_addr, out_valid_reg && (out_sts_reg != STS_DONE),
        out_addr_reg == 32'd0, "failed item carries an address")
    `FFHA_ASSERT_IMP(a_ready_drop, $fell(init_done_reg),
        ($past(state_reg) == S_START) && ($past(act_reg) == ACT_CLEAR),
        "heap ready dropped without a clear")

endmodule

`default_nettype wire

// ----- src/ffha_table.sv -----
// ---------------------------------------------------------------------------
// ffha_table
// Block table: record, next-link and prev-link memories, one shared
// read address with registered read data, one write port each.
// ---------------------------------------------------------------------------
`default_nettype none

module ffha_table
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int IW = $clog2(MAX_BLOCKS),
    localparam int LW = $clog2(MAX_BLOCKS + 1)
)
(
    input  wire logic          clk,
    input  wire logic [IW-1:0] rd_idx,
    output blk_t               rd_data,
    output logic [LW-1:0]      rd_nxt,
    output logic [LW-1:0]      rd_prv,
    input  wire logic          dat_we,
    input  wire logic [IW-1:0] dat_idx,
    input  blk_t               dat_wd,
    input  wire logic          nxt_we,
    input  wire logic [IW-1:0] nxt_idx,
    input  wire logic [LW-1:0] nxt_wd,
    input  wire logic          prv_we,
    input  wire logic [IW-1:0] prv_idx,
    input  wire logic [LW-1:0] prv_wd
);

    blk_t          dat_mem [MAX_BLOCKS];
    logic [LW-1:0] nxt_mem [MAX_BLOCKS];
    logic [LW-1:0] prv_mem [MAX_BLOCKS];

    blk_t          rd_dat_reg;
    logic [LW-1:0] rd_nxt_reg;
    logic [LW-1:0] rd_prv_reg;

    always_ff @(posedge clk)
    begin
        rd_dat_reg <= dat_mem[rd_idx];
        rd_nxt_reg <= nxt_mem[rd_idx];
        rd_prv_reg <= prv_mem[rd_idx];
        if (dat_we)
        begin
            dat_mem[dat_idx] <= dat_wd;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_idx] <= nxt_wd;
        end
        if (prv_we)
        begin
            prv_mem[prv_idx] <= prv_wd;
        end
    end

    assign rd_data = rd_dat_reg;
    assign rd_nxt  = rd_nxt_reg;
    assign rd_prv  = rd_prv_reg;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate, free, resize, sizes, clear and init items over several
// heap settings. A local model of the block table predicts every result, and
// each result is checked field by field against it.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import ffha_pkg::*;

    localparam int unsigned NBLK  = 64;
    localparam int unsigned HDR   = 16;
    localparam int unsigned NIL   = NBLK;
    localparam int unsigned DRAIN = 300;
    localparam logic [2:0]  ACT_UNDEF = 3'd7;

    typedef struct {
        logic [2:0]  act;
        logic [31:0] addr;
        logic [23:0] req;
    } alloc_item_t;

    typedef struct {
        logic [1:0]  sts;
        logic [31:0] addr;
        logic [23:0] big;
        logic [23:0] tfree;
        logic [23:0] talloc;
        logic        rdy;
    } alloc_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = '0;
    logic [31:0] block_address = '0;
    logic [23:0] request_bytes = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] result_address;
    logic [23:0] largest_free;
    logic [23:0] total_free;
    logic [23:0] total_alloc;
    logic        heap_ready;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    first_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .block_address(block_address), .request_bytes(request_bytes),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_address(result_address),
        .largest_free(largest_free), .total_free(total_free),
        .total_alloc(total_alloc), .heap_ready(heap_ready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of the block table
    int unsigned blk_ofs [NBLK];
    int unsigned blk_pay [NBLK];
    bit          blk_free[NBLK];
    bit          blk_used[NBLK];
    int unsigned nxt[NBLK];
    int unsigned prv[NBLK];
    int unsigned head = NIL;
    bit          heap_up = 1'b0;
    int unsigned base_reg = 0, size_reg = 0, base_lat = 0;

    alloc_item_t pending_items[$];
    alloc_res_t  expected_res[$];
    alloc_item_t drv_item;
    int unsigned cyc = 0;
    int unsigned n_sent = 0, n_recv = 0, n_bad = 0;
    int unsigned n_full = 0, n_nospace = 0, n_ignored = 0;

    function automatic int unsigned addr_of(int unsigned e);
        return base_lat + blk_ofs[e] + HDR;
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < NBLK; i++)
        begin
            blk_used[i] = 1'b0;
            blk_free[i] = 1'b0;
        end
        head = NIL;
    endfunction

    function automatic int unsigned grab_entry();
        for (int i = 0; i < NBLK; i++)
            if (!blk_used[i])
            begin
                blk_used[i] = 1'b1;
                return i;
            end
        return NIL;
    endfunction

    function automatic void link_after(int unsigned e, int unsigned n);
        int unsigned q;
        q = nxt[e];
        prv[n] = e;
        nxt[n] = q;
        if (q < NBLK) prv[q] = n;
        nxt[e] = n;
    endfunction

    function automatic void unlink(int unsigned n);
        int unsigned p, q;
        p = prv[n];
        q = nxt[n];
        if (p < NBLK) nxt[p] = q;
        else head = q;
        if (q < NBLK) prv[q] = p;
        blk_used[n] = 1'b0;
    endfunction

    function automatic int unsigned round16(int unsigned v);
        return (v + 15) & 32'hFFFF_FFF0;
    endfunction

    function automatic sts_t take_front(int unsigned size, output int unsigned a);
        int unsigned e, n, blk;
        e = head;
        a = 0;
        for (int s = 0; s < NBLK && e < NBLK; s++)
        begin
            if (blk_free[e] && blk_pay[e] >= size)
            begin
                blk = size + HDR;
                if (blk < blk_pay[e])
                begin
                    n = grab_entry();
                    if (n == NIL) return STS_TABLE_FULL;
                    blk_ofs[n]  = blk_ofs[e] + blk;
                    blk_pay[n]  = blk_pay[e] - blk;
                    blk_free[n] = 1'b1;
                    link_after(e, n);
                    blk_pay[e] = size;
                end
                blk_free[e] = 1'b0;
                a = addr_of(e);
                return STS_DONE;
            end
            e = nxt[e];
        end
        return STS_NO_SPACE;
    endfunction

    function automatic sts_t take_back(int unsigned size, output int unsigned a);
        int unsigned e, n, blk;
        e = head;
        a = 0;
        if (e >= NBLK) return STS_NO_SPACE;
        for (int s = 0; s < NBLK && nxt[e] < NBLK; s++)
            e = nxt[e];
        for (int s = 0; s < NBLK && e < NBLK; s++)
        begin
            if (blk_free[e] && blk_pay[e] >= size)
            begin
                blk = size + HDR;
                if (blk < blk_pay[e])
                begin
                    n = grab_entry();
                    if (n == NIL) return STS_TABLE_FULL;
                    blk_ofs[n] = blk_ofs[e] + blk_pay[e] - size;
                    blk_pay[n] = size;
                    link_after(e, n);
                    blk_pay[e] -= blk;
                    e = n;
                end
                blk_free[e] = 1'b0;
                a = addr_of(e);
                return STS_DONE;
            end
            e = prv[e];
        end
        return STS_NO_SPACE;
    endfunction

    function automatic int unsigned find_blk(int unsigned a);
        int unsigned e;
        e = head;
        for (int s = 0; s < NBLK && e < NBLK; s++)
        begin
            if (addr_of(e) == a) return e;
            e = nxt[e];
        end
        return NIL;
    endfunction

    function automatic sts_t release_blk(int unsigned a);
        int unsigned e, p, q;
        if (a == 0) return STS_IGNORED;
        e = find_blk(a);
        if (e == NIL || blk_free[e]) return STS_IGNORED;
        blk_free[e] = 1'b1;
        q = nxt[e];
        if (q < NBLK && blk_free[q] && blk_ofs[q] == blk_ofs[e] + HDR + blk_pay[e])
        begin
            blk_pay[e] += blk_pay[q] + HDR;
            unlink(q);
        end
        p = prv[e];
        if (p < NBLK && blk_free[p] && blk_ofs[e] == blk_ofs[p] + HDR + blk_pay[p])
        begin
            blk_pay[p] += blk_pay[e] + HDR;
            unlink(e);
        end
        return STS_DONE;
    endfunction

    function automatic sts_t resize_blk(int unsigned a, int unsigned req,
                                        output int unsigned oa);
        int unsigned e, size, q, diff, na;
        sts_t st;
        oa = 0;
        if (a == 0) return take_front(round16(req), oa);
        if (req == 0) return release_blk(a);
        e = find_blk(a);
        if (e == NIL || blk_free[e]) return STS_IGNORED;
        size = round16(req);
        if (size > blk_pay[e])
        begin
            diff = size - blk_pay[e];
            q = nxt[e];
            if (q < NBLK && blk_free[q] && blk_pay[q] >= diff &&
                blk_ofs[q] == blk_ofs[e] + HDR + blk_pay[e])
            begin
                blk_pay[q] -= diff;
                blk_ofs[q] += diff;
                blk_pay[e] = size;
            end
            else
            begin
                st = take_front(size, na);
                if (st != STS_DONE) return st;
                void'(release_blk(a));
                oa = na;
                return STS_DONE;
            end
        end
        oa = a;
        return STS_DONE;
    endfunction

    function automatic sts_t init_heap();
        int unsigned diff, asz;
        diff = (0 - base_reg) & 15;
        empty_table();
        heap_up = 1'b1;
        base_lat = base_reg + diff;
        if (base_reg == 0 || size_reg < diff) return STS_NO_SPACE;
        asz = (size_reg - diff) & 32'hFFFF_FFF0;
        if (asz <= HDR) return STS_NO_SPACE;
        blk_used[0] = 1'b1;
        blk_ofs[0]  = 0;
        blk_pay[0]  = asz - HDR;
        blk_free[0] = 1'b1;
        nxt[0] = NIL;
        prv[0] = NIL;
        head = 0;
        return STS_DONE;
    endfunction

    function automatic alloc_res_t predict_alloc(alloc_item_t it);
        alloc_res_t r;
        int unsigned a, big, tf, ta, e;
        sts_t st;
        a = 0; big = 0; tf = 0; ta = 0;
        st = STS_DONE;
        case (it.act)
            ACT_ALLOC_FRONT: st = take_front(round16(it.req), a);
            ACT_ALLOC_BACK:  st = take_back(round16(it.req), a);
            ACT_FREE:        st = release_blk(it.addr);
            ACT_RESIZE:      st = resize_blk(it.addr, it.req, a);
            ACT_SIZES:
            begin
                e = head;
                for (int s = 0; s < NBLK && e < NBLK; s++)
                begin
                    if (blk_free[e])
                    begin
                        tf += blk_pay[e];
                        if (big < blk_pay[e]) big = blk_pay[e];
                    end
                    else
                        ta += blk_pay[e];
                    e = nxt[e];
                end
            end
            ACT_CLEAR:
            begin
                empty_table();
                heap_up = 1'b0;
            end
            ACT_INIT:        st = init_heap();
            default:         st = STS_IGNORED;
        endcase
        if (st != STS_DONE) a = 0;
        r.sts = st;
        r.addr = a;
        r.big = big[23:0];
        r.tfree = tf[23:0];
        r.talloc = ta[23:0];
        r.rdy = heap_up;
        return r;
    endfunction

    // ---------------- driver ----------------
    function automatic bit quiet_window();
        return cyc >= 40000 && cyc < 52000;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cyc <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (in_valid && !in_stall)
            begin
                expected_res.push_back(predict_alloc(drv_item));
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 &&
                    (quiet_window() || $urandom_range(99) >= 7))
                begin
                    drv_item = pending_items.pop_front();
                    action <= drv_item.act;
                    block_address <= drv_item.addr;
                    request_bytes <= drv_item.req;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && cyc >= 20000)
        begin
            hold_done <= 1'b1;
            hold_left <= 600;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet_window() && $urandom_range(99) < 7;
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        alloc_res_t ex;
        if (rst_n && out_valid && !out_stall)
        begin
            n_recv++;
            if (expected_res.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: status=%0d addr=%h", status, result_address);
            end
            else
            begin
                ex = expected_res.pop_front();
                if (ex.sts == STS_TABLE_FULL) n_full++;
                if (ex.sts == STS_NO_SPACE) n_nospace++;
                if (ex.sts == STS_IGNORED) n_ignored++;
                if (status !== ex.sts || result_address !== ex.addr ||
                    largest_free !== ex.big || total_free !== ex.tfree ||
                    total_alloc !== ex.talloc || heap_ready !== ex.rdy)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch #%0d: exp sts=%0d addr=%h big=%h free=%h alloc=%h rdy=%b, got sts=%0d addr=%h big=%h free=%h alloc=%h rdy=%b",
                                 n_recv, ex.sts, ex.addr, ex.big, ex.tfree, ex.talloc, ex.rdy,
                                 status, result_address, largest_free, total_free,
                                 total_alloc, heap_ready);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic int unsigned pick_addr(bit want_free);
        int unsigned e, hits[$];
        e = head;
        for (int s = 0; s < NBLK && e < NBLK; s++)
        begin
            if (blk_free[e] == want_free) hits.push_back(addr_of(e));
            e = nxt[e];
        end
        if (hits.size() == 0) return 0;
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    function automatic logic [23:0] rand_req(int unsigned smallmax);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return 24'd0;
        if (r < 9) return $urandom;
        if (r < 11) return 24'hFFFFFF;
        return $urandom_range(smallmax);
    endfunction

    task automatic push_item(logic [2:0] a, logic [31:0] ad, logic [23:0] rq);
        alloc_item_t it;
        while (pending_items.size() > 1) @(posedge clk);
        it.act = a;
        it.addr = ad;
        it.req = rq;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_res.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_HEAP_BASE) base_reg = val;
        else size_reg = val[23:0];
        cfg_valid <= 1'b0;
    endtask

    // alloc_w: weight of allocations, smallmax: typical request size
    task automatic random_phase(int n, int alloc_w, int unsigned smallmax);
        int r;
        int unsigned pa;
        push_item(ACT_INIT, $urandom, $urandom);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < alloc_w)
                push_item($urandom_range(1) ? ACT_ALLOC_BACK : ACT_ALLOC_FRONT,
                          $urandom, rand_req(smallmax));
            else if (r < alloc_w + 25)
            begin
                pa = ($urandom_range(9) < 8) ? pick_addr(1'b0) : pick_addr(1'b1);
                if ($urandom_range(19) == 0) pa = $urandom;
                push_item(ACT_FREE, pa, $urandom);
            end
            else if (r < alloc_w + 42)
            begin
                pa = pick_addr(1'b0);
                if ($urandom_range(9) == 0) pa = 0;
                else if ($urandom_range(19) == 0) pa = $urandom;
                push_item(ACT_RESIZE, pa, rand_req(smallmax * 2));
            end
            else if (r < alloc_w + 52)
                push_item(ACT_SIZES, $urandom, $urandom);
            else if (r < alloc_w + 54)
                push_item(ACT_CLEAR, $urandom, $urandom);
            else if (r < alloc_w + 58)
                push_item(ACT_INIT, $urandom, $urandom);
            else
                push_item(ACT_UNDEF, $urandom, $urandom);
        end
        wait_idle();
    endtask

    initial
    begin
        int unsigned pa;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: before init, empty heap, extremes, each resize case
        write_reg(CFG_HEAP_BASE, 32'h0000_1000);
        write_reg(CFG_HEAP_SIZE, 24'h001000);
        push_item(ACT_SIZES, 0, 0);
        push_item(ACT_ALLOC_FRONT, 0, 24'd16);
        push_item(ACT_FREE, 0, 0);
        push_item(ACT_INIT, 0, 0);
        push_item(ACT_ALLOC_FRONT, 0, 24'd0);
        push_item(ACT_ALLOC_FRONT, 0, 24'hFFFFFF);
        push_item(ACT_ALLOC_FRONT, 0, 24'd20);
        push_item(ACT_ALLOC_BACK, 0, 24'd40);
        push_item(ACT_SIZES, 0, 0);
        push_item(ACT_FREE, 32'h0000_1234, 0);
        wait_idle();
        pa = pick_addr(1'b0);
        push_item(ACT_FREE, pa, 0);
        push_item(ACT_FREE, pa, 0);
        push_item(ACT_RESIZE, 0, 24'd32);
        wait_idle();
        push_item(ACT_RESIZE, pick_addr(1'b0), 24'd0);
        wait_idle();
        pa = pick_addr(1'b0);
        push_item(ACT_RESIZE, pa, 24'd1);
        push_item(ACT_RESIZE, pa, 24'd200);
        push_item(ACT_RESIZE, 32'hDEAD_BEE0, 24'd64);
        wait_idle();
        push_item(ACT_RESIZE, pick_addr(1'b0), 24'd3000);
        push_item(ACT_RESIZE, pick_addr(1'b0), 24'hFFFFFF);
        push_item(ACT_UNDEF, 32'hFFFF_FFFF, 24'hFFFFFF);
        push_item(ACT_CLEAR, 0, 0);
        push_item(ACT_ALLOC_BACK, 0, 24'd16);
        push_item(ACT_INIT, 0, 0);
        wait_idle();

        random_phase(150, 30, 200);

        // zero base: init fails but the heap still reports ready
        write_reg(CFG_HEAP_BASE, 32'h0);
        write_reg(CFG_HEAP_SIZE, 24'hFFFFFF);
        random_phase(40, 30, 200);

        // addresses wrap past the top of the address space
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF1);
        random_phase(250, 30, 4000);

        // many tiny blocks to run the table out of entries
        write_reg(CFG_HEAP_BASE, 32'h1234_5678);
        write_reg(CFG_HEAP_SIZE, 24'h002000);
        random_phase(250, 60, 40);

        // region only just above one header
        write_reg(CFG_HEAP_BASE, $urandom | 32'h1);
        write_reg(CFG_HEAP_SIZE, 24'h000037);
        random_phase(60, 35, 40);

        // region gone after alignment
        write_reg(CFG_HEAP_BASE, 32'h8000_0003);
        write_reg(CFG_HEAP_SIZE, 24'h000015);
        random_phase(20, 30, 40);

        write_reg(CFG_HEAP_BASE, 32'h0000_2000);
        write_reg(CFG_HEAP_SIZE, 24'h020000);
        random_phase(250, 40, 2000);

        $display("covered %0d items, %0d results: %0d table full, %0d no space, %0d ignored",
                 n_sent, n_recv, n_full, n_nospace, n_ignored);
        $display("heap settings from empty to full-range size, wrapping and zero base");
        if (n_bad == 0 && expected_res.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches", n_bad);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("timeout with %0d results outstanding", expected_res.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
